@@ src/gvc_pkg.sv @@
// Shared types, constants and helpers of the gamepad event and velocity conditioner.
package gvc_pkg;

  localparam int unsigned AXIS_FRAC_BITS  = 14;
  localparam int unsigned ZERO_HOLD_TICKS = 10;
  localparam int unsigned RECONNECT_TICKS = 20;
  localparam int unsigned SILENCE_TICKS   = 10;

  localparam int unsigned EV_COUNT   = 15;
  localparam int unsigned HELD_W     = 17;
  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned CFG_W      = 15;
  localparam int unsigned SIL_W      = 5;
  localparam int unsigned ZH_W       = 4;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned EV_IDX_W   = 4;

  localparam logic [CFG_W-1:0] LIN_GAIN_RST  = 15'd16384;
  localparam logic [CFG_W-1:0] ANG_GAIN_RST  = 15'd4915;
  localparam logic [CFG_W-1:0] DEADBAND_RST  = 15'd1638;
  localparam logic [CFG_W-1:0] ZERO_BAND_RST = 15'd164;

  // Half of one in axis units, for the d-pad thresholds.
  localparam logic signed [AXIS_W:0] AXIS_HALF     = 17'sd1 <<< (AXIS_FRAC_BITS - 1);
  localparam logic signed [AXIS_W:0] AXIS_HALF_NEG = -AXIS_HALF;
  // Rounding offset for the gain product.
  localparam logic [PROD_W-1:0] ROUND_HALF = 32'd1 << (AXIS_FRAC_BITS - 1);

  localparam logic [SIL_W-1:0] SIL_MAX       = '1;
  localparam logic [SIL_W-1:0] SIL_CLEAR_AT  = SIL_W'(SILENCE_TICKS);
  localparam logic [SIL_W-1:0] SIL_RECONNECT = SIL_W'(RECONNECT_TICKS);
  localparam logic [ZH_W-1:0]  ZH_RELOAD     = ZH_W'(ZERO_HOLD_TICKS);

  typedef enum logic [1:0] {
    CFG_LINEAR_GAIN      = 2'd0,
    CFG_ANGULAR_GAIN     = 2'd1,
    CFG_STICK_DEADBAND   = 2'd2,
    CFG_OUTPUT_ZERO_BAND = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_SNAPSHOT = 1'b0,
    OP_TICK     = 1'b1
  } op_e;

  typedef enum logic {
    KIND_EVENT    = 1'b0,
    KIND_VELOCITY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    MOD_NONE  = 2'd0,
    MOD_RIGHT = 2'd1,
    MOD_LEFT  = 2'd2
  } mod_e;

  typedef struct packed {
    op_e                      op;
    logic [10:0]              button_bits;
    logic signed [AXIS_W-1:0] left_stick_x;
    logic signed [AXIS_W-1:0] left_stick_y;
    logic signed [AXIS_W-1:0] right_stick_x;
    logic signed [AXIS_W-1:0] left_trigger_axis;
    logic signed [AXIS_W-1:0] right_trigger_axis;
    logic signed [AXIS_W-1:0] dpad_horizontal;
    logic signed [AXIS_W-1:0] dpad_vertical;
  } gvc_in_t;

  typedef struct packed {
    kind_e                    kind;
    logic [EV_IDX_W-1:0]      event_signal;
    logic                     event_release;
    mod_e                     event_modifier;
    logic signed [AXIS_W-1:0] forward_velocity;
    logic signed [AXIS_W-1:0] lateral_velocity;
    logic signed [AXIS_W-1:0] turn_rate;
    logic                     last;
  } gvc_out_t;

  // Everything one tick leaves for the output sequencer.
  typedef struct packed {
    logic [EV_COUNT-1:0]      edges;
    logic [EV_COUNT-1:0]      level;
    mod_e                     modifier;
    logic                     vel_valid;
    logic signed [AXIS_W-1:0] fwd;
    logic signed [AXIS_W-1:0] lat;
    logic signed [AXIS_W-1:0] turn;
  } gvc_rec_t;

  // Reorder held signals into event order.
  function automatic logic [EV_COUNT-1:0] event_vec(input logic [HELD_W-1:0] h);
    event_vec = {h[16], h[15], h[14], h[13], h[10], h[9], h[5], h[4],
                 h[6], h[8], h[7], h[3], h[2], h[1], h[0]};
  endfunction

  // Magnitude of a signed axis, one bit wider so that the most negative code fits.
  function automatic logic [AXIS_W:0] axis_mag(input logic signed [AXIS_W-1:0] v);
    logic [AXIS_W:0] ext;
    ext = {v[AXIS_W-1], v};
    axis_mag = v[AXIS_W-1] ? (~ext + 17'd1) : ext;
  endfunction

endpackage

@@ src/gvc_stream_if.sv @@
// Valid/ready stream channel carrying one payload item.
interface gvc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/gamepad_event_and_velocity_conditioner.sv @@
// Top level of the gamepad event and velocity conditioner.
// A snapshot item passes the input register into the held gamepad state and gives
// no result. A tick item passes an input register, where the watchdog, edge
// detection and the three deadbanded gain products are worked out, then a rounding
// stage, where the velocity is saturated, zero-banded and the zero-hold count
// updated, and then the output sequencer, which hands out its results one per cycle
// while the receiver is ready: up to 15 events in event order and then at most one
// velocity command, the final one flagged last. Input items are accepted every
// cycle while the sequencer can take the next tick.
module gamepad_event_and_velocity_conditioner (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  gvc_pkg::cfg_reg_e           cfg_idx_i,
  input  logic [gvc_pkg::CFG_W-1:0]   cfg_data_i,
  gvc_stream_if.sink                  item_i,
  gvc_stream_if.source                result_o
);
  import gvc_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] lin_gain_q, ang_gain_q, deadband_q, zero_band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q  <= LIN_GAIN_RST;
      ang_gain_q  <= ANG_GAIN_RST;
      deadband_q  <= DEADBAND_RST;
      zero_band_q <= ZERO_BAND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINEAR_GAIN:      lin_gain_q  <= cfg_data_i;
        CFG_ANGULAR_GAIN:     ang_gain_q  <= cfg_data_i;
        CFG_STICK_DEADBAND:   deadband_q  <= cfg_data_i;
        CFG_OUTPUT_ZERO_BAND: zero_band_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  logic    a_valid_q, a_is_tick, a_go, in_fire, b_ready;
  gvc_in_t a_item_q;

  assign a_is_tick    = a_item_q.op == OP_TICK;
  assign a_go         = a_valid_q && (!a_is_tick || b_ready);
  assign item_i.ready = !a_valid_q || a_go;
  assign in_fire      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      a_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_item_q <= item_i.data;
    end
  end

  // Held gamepad state
  logic [HELD_W-1:0]        held_q;
  logic signed [AXIS_W-1:0] axes_q [3];
  logic [EV_COUNT-1:0]      prev_q;
  logic                     first_q;
  logic [SIL_W-1:0]         silence_q;

  logic signed [AXIS_W:0]   dh, dv;
  logic [HELD_W-1:0]        snap_sig, held_eff;
  logic signed [AXIS_W-1:0] axes_eff [3];
  logic [SIL_W-1:0]         sil_inc;
  logic                     wd_clear;
  logic [EV_COUNT-1:0]      cur, prev_eff, edges;
  mod_e                     mod;
  logic [AXIS_W:0]          mag [3];
  logic [CFG_W-1:0]         gain [3];
  logic [PROD_W-1:0]        prod [3];

  assign dh = a_item_q.dpad_horizontal;
  assign dv = a_item_q.dpad_vertical;
  assign snap_sig = {dv < AXIS_HALF_NEG, dv > AXIS_HALF, dh < AXIS_HALF_NEG, dh > AXIS_HALF,
                     a_item_q.right_trigger_axis[AXIS_W-1],
                     a_item_q.left_trigger_axis[AXIS_W-1],
                     a_item_q.button_bits};

  assign sil_inc  = (silence_q == SIL_MAX) ? silence_q : silence_q + 5'd1;
  assign wd_clear = sil_inc == SIL_CLEAR_AT;
  assign held_eff = wd_clear ? '0 : held_q;
  assign cur      = event_vec(held_eff);
  assign prev_eff = first_q ? cur : prev_q;
  assign edges    = cur ^ prev_eff;

  always_comb begin
    if (held_eff[12]) begin
      mod = MOD_RIGHT;
    end else if (held_eff[11]) begin
      mod = MOD_LEFT;
    end else begin
      mod = MOD_NONE;
    end
  end

  assign gain[0] = lin_gain_q;
  assign gain[1] = lin_gain_q;
  assign gain[2] = ang_gain_q;

  // Lanes: 0 lateral (left x), 1 forward (left y), 2 turn (right x).
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      axes_eff[j] = wd_clear ? '0 : axes_q[j];
      mag[j]      = axis_mag(axes_eff[j]);
      prod[j]     = (mag[j] < {2'b00, deadband_q}) ? '0 : PROD_W'(mag[j]) * PROD_W'(gain[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      prev_q    <= '0;
      first_q   <= 1'b1;
      silence_q <= '0;
      for (int j = 0; j < 3; j++) begin
        axes_q[j] <= '0;
      end
    end else if (a_go) begin
      if (a_is_tick) begin
        held_q    <= held_eff;
        prev_q    <= cur;
        first_q   <= 1'b0;
        silence_q <= sil_inc;
        for (int j = 0; j < 3; j++) begin
          axes_q[j] <= axes_eff[j];
        end
      end else begin
        // Long silence means the pad came back: suppress edges on the next tick.
        if (silence_q >= SIL_RECONNECT) begin
          first_q <= 1'b1;
        end
        silence_q <= '0;
        held_q    <= snap_sig;
        axes_q[0] <= a_item_q.left_stick_x;
        axes_q[1] <= a_item_q.left_stick_y;
        axes_q[2] <= a_item_q.right_stick_x;
      end
    end
  end

  // Rounding stage
  logic                b_valid_q, b_go, b_has_res, rec_ready;
  logic [EV_COUNT-1:0] b_edges_q, b_level_q;
  mod_e                b_mod_q;
  logic [PROD_W-1:0]   b_prod_q [3];
  logic                b_neg_q [3];
  logic [ZH_W-1:0]     zh_q, zh_next;

  logic [PROD_W-1:0]        rsum [3];
  logic [PROD_W-1:0]        rshift [3];
  logic [CFG_W-1:0]         sat [3];
  logic [2:0]               small_mag;
  logic                     all_zero, vel_valid;
  logic signed [AXIS_W-1:0] vel [3];
  gvc_rec_t                 rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_go && a_is_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go && a_is_tick && b_ready) begin
      b_edges_q <= edges;
      b_level_q <= cur;
      b_mod_q   <= mod;
      for (int j = 0; j < 3; j++) begin
        b_prod_q[j] <= prod[j];
        b_neg_q[j]  <= axes_eff[j][AXIS_W-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rsum[j]      = b_prod_q[j] + ROUND_HALF;
      rshift[j]    = rsum[j] >> AXIS_FRAC_BITS;
      sat[j]       = (|rshift[j][PROD_W-1:CFG_W]) ? '1 : rshift[j][CFG_W-1:0];
      small_mag[j] = sat[j] <= zero_band_q;
    end
  end

  assign all_zero = &small_mag;

  always_comb begin
    if (all_zero) begin
      zh_next = (zh_q != '0) ? zh_q - 4'd1 : zh_q;
    end else begin
      zh_next = ZH_RELOAD;
    end
    for (int j = 0; j < 3; j++) begin
      if (all_zero) begin
        vel[j] = '0;
      end else if (b_neg_q[j]) begin
        vel[j] = -$signed({1'b0, sat[j]});
      end else begin
        vel[j] = $signed({1'b0, sat[j]});
      end
    end
  end

  assign vel_valid = zh_next != '0;
  assign b_has_res = (|b_edges_q) || vel_valid;
  assign b_go      = b_valid_q && (!b_has_res || rec_ready);
  assign b_ready   = !b_valid_q || b_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zh_q <= ZH_RELOAD;
    end else if (b_go) begin
      zh_q <= zh_next;
    end
  end

  always_comb begin
    rec.edges     = b_edges_q;
    rec.level     = b_level_q;
    rec.modifier  = b_mod_q;
    rec.vel_valid = vel_valid;
    rec.lat       = vel[0];
    rec.fwd       = vel[1];
    rec.turn      = vel[2];
  end

  gvc_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (b_valid_q && b_has_res),
    .rec_i       (rec),
    .rec_ready_o (rec_ready),
    .result_o    (result_o)
  );

endmodule

@@ src/gvc_sequencer.sv @@
// Output sequencer: emits the events and velocity of one tick, one item per cycle while the receiver is ready.
module gvc_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rec_valid_i,
  input  gvc_pkg::gvc_rec_t rec_i,
  output logic              rec_ready_o,
  gvc_stream_if.source      result_o
);
  import gvc_pkg::*;

  logic                s_valid_q, s_valid_d;
  gvc_rec_t            s_rec_q;
  logic [EV_COUNT-1:0] low_bit, rest;
  logic [EV_IDX_W-1:0] ev_idx;
  logic                has_ev, is_last, take, load;

  always_comb begin
    ev_idx = '0;
    for (int k = EV_COUNT - 1; k >= 0; k--) begin
      if (s_rec_q.edges[k]) begin
        ev_idx = EV_IDX_W'(k);
      end
    end
  end

  assign low_bit = s_rec_q.edges & (~s_rec_q.edges + 15'd1);
  assign rest    = s_rec_q.edges & ~low_bit;
  assign has_ev  = |s_rec_q.edges;
  assign is_last = has_ev ? (~|rest && !s_rec_q.vel_valid) : 1'b1;
  assign take    = s_valid_q && result_o.ready;

  assign rec_ready_o = !s_valid_q || (take && is_last);
  assign load        = rec_valid_i && rec_ready_o;

  always_comb begin
    s_valid_d = s_valid_q;
    if (load) begin
      s_valid_d = 1'b1;
    end else if (take && is_last) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  // Drop the item just taken from the record, or load the next tick.
  always_ff @(posedge clk_i) begin
    if (load) begin
      s_rec_q <= rec_i;
    end else if (take) begin
      if (has_ev) begin
        s_rec_q.edges <= rest;
      end else begin
        s_rec_q.vel_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    result_o.valid = s_valid_q;
    result_o.data  = '0;
    result_o.data.last = is_last;
    if (has_ev) begin
      result_o.data.kind           = KIND_EVENT;
      result_o.data.event_signal   = ev_idx;
      result_o.data.event_release  = ~|(s_rec_q.level & low_bit);
      result_o.data.event_modifier = s_rec_q.modifier;
    end else begin
      result_o.data.kind             = KIND_VELOCITY;
      result_o.data.event_modifier   = MOD_NONE;
      result_o.data.forward_velocity = s_rec_q.fwd;
      result_o.data.lateral_velocity = s_rec_q.lat;
      result_o.data.turn_rate        = s_rec_q.turn;
    end
  end

endmodule

@@ verif/gvc_result_checker.sv @@
// Result checker: watches both channels, predicts each tick's results and compares them.
`timescale 1ns / 100ps
module gvc_result_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  gvc_pkg::cfg_reg_e          cfg_idx_i,
  input  logic [gvc_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       item_valid_i,
  input  logic                       item_ready_i,
  input  gvc_pkg::gvc_in_t           item_data_i,
  input  logic                       result_valid_i,
  input  logic                       result_ready_i,
  input  gvc_pkg::gvc_out_t          result_data_i,
  output int unsigned                error_count_o,
  output int unsigned                pending_o
);
  import gvc_pkg::*;

  localparam int HALF_ONE  = 1 << (AXIS_FRAC_BITS - 1);
  localparam int OUT_MAX   = 32767;
  localparam int QUIET_MAX = 31;

  logic [CFG_W-1:0]         lin_gain;
  logic [CFG_W-1:0]         ang_gain;
  logic [CFG_W-1:0]         deadband;
  logic [CFG_W-1:0]         zero_band;

  logic [HELD_W-1:0]        held;
  logic signed [AXIS_W-1:0] axis_lx;
  logic signed [AXIS_W-1:0] axis_ly;
  logic signed [AXIS_W-1:0] axis_rx;
  logic [EV_COUNT-1:0]      prev_level;
  logic                     fresh;
  logic [SIL_W-1:0]         quiet_ticks;
  logic [ZH_W-1:0]          zero_run;

  gvc_out_t    owed_q[$];
  int unsigned errors    = 0;
  int unsigned result_no = 0;
  int unsigned pending   = 0;

  assign error_count_o = errors;
  assign pending_o     = pending;

  // Bit of the held signals that feeds each event index.
  function automatic int unsigned held_bit(input int unsigned ev);
    case (ev)
      4:       held_bit = 7;   // START
      5:       held_bit = 8;   // HOME
      6:       held_bit = 6;   // BACK
      7:       held_bit = 4;   // LB
      8:       held_bit = 5;   // RB
      11:      held_bit = 13;  // d-pad left
      12:      held_bit = 14;  // d-pad right
      13:      held_bit = 15;  // d-pad up
      14:      held_bit = 16;  // d-pad down
      default: held_bit = ev;  // face buttons and stick clicks keep their place
    endcase
  endfunction

  // Deadband, gain and round half away from zero, saturated to the output range.
  function automatic int scaled_axis(input logic signed [AXIS_W-1:0] v,
                                     input logic [CFG_W-1:0] gain,
                                     input logic [CFG_W-1:0] db);
    int     sv;
    longint mag;
    longint p;
    sv  = v;
    mag = (sv < 0) ? -sv : sv;
    if (mag < longint'(db)) return 0;
    p = (mag * longint'(gain) + (longint'(1) << (AXIS_FRAC_BITS - 1))) >>> AXIS_FRAC_BITS;
    if (p > OUT_MAX) p = OUT_MAX;
    return (sv < 0) ? -int'(p) : int'(p);
  endfunction

  task automatic absorb_snapshot(input gvc_in_t d);
    held = {int'(d.dpad_vertical) < -HALF_ONE, int'(d.dpad_vertical) > HALF_ONE,
            int'(d.dpad_horizontal) < -HALF_ONE, int'(d.dpad_horizontal) > HALF_ONE,
            int'(d.right_trigger_axis) < 0, int'(d.left_trigger_axis) < 0,
            d.button_bits};
    // A long silence means the pad came back: suppress edges on the next tick.
    if (quiet_ticks >= RECONNECT_TICKS) fresh = 1'b1;
    quiet_ticks = '0;
    axis_lx = d.left_stick_x;
    axis_ly = d.left_stick_y;
    axis_rx = d.right_stick_x;
  endtask

  task automatic run_tick();
    logic [EV_COUNT-1:0] level;
    mod_e                mod;
    int                  fwd;
    int                  lat;
    int                  turn;
    int unsigned         i;
    gvc_out_t            rec;
    gvc_out_t            batch[$];
    if (quiet_ticks < QUIET_MAX) quiet_ticks++;
    if (quiet_ticks == SILENCE_TICKS) begin
      held    = '0;
      axis_lx = '0;
      axis_ly = '0;
      axis_rx = '0;
    end
    for (i = 0; i < EV_COUNT; i++) level[i] = held[held_bit(i)];
    if (fresh) begin
      prev_level = level;
      fresh      = 1'b0;
    end
    mod = held[12] ? MOD_RIGHT : (held[11] ? MOD_LEFT : MOD_NONE);
    for (i = 0; i < EV_COUNT; i++) begin
      if (level[i] != prev_level[i]) begin
        rec                = '0;
        rec.kind           = KIND_EVENT;
        rec.event_signal   = EV_IDX_W'(i);
        rec.event_release  = ~level[i];
        rec.event_modifier = mod;
        batch.insert(batch.size(), rec);
      end
    end
    fwd  = scaled_axis(axis_ly, lin_gain, deadband);
    lat  = scaled_axis(axis_lx, lin_gain, deadband);
    turn = scaled_axis(axis_rx, ang_gain, deadband);
    if ((fwd < 0 ? -fwd : fwd) <= int'(zero_band) &&
        (lat < 0 ? -lat : lat) <= int'(zero_band) &&
        (turn < 0 ? -turn : turn) <= int'(zero_band)) begin
      fwd  = 0;
      lat  = 0;
      turn = 0;
      if (zero_run != 0) zero_run--;
    end else begin
      zero_run = ZH_W'(ZERO_HOLD_TICKS);
    end
    if (zero_run != 0) begin
      rec                  = '0;
      rec.kind             = KIND_VELOCITY;
      rec.forward_velocity = AXIS_W'(fwd);
      rec.lateral_velocity = AXIS_W'(lat);
      rec.turn_rate        = AXIS_W'(turn);
      batch.insert(batch.size(), rec);
    end
    prev_level = level;
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) owed_q.insert(owed_q.size(), batch[k]);
  endtask

  task automatic show_field(input string field, input int want_v, input int got_v);
    $display("%0t: result %0d %s expected %0d got %0d", $time, result_no, field,
             want_v, got_v);
  endtask

  task automatic check_result(input gvc_out_t got);
    gvc_out_t want;
    bit       bad;
    result_no++;
    if (owed_q.size() == 0) begin
      errors++;
      $display("%0t: result %0d expected none got %h", $time, result_no, got);
      return;
    end
    want = owed_q.pop_front();
    bad  = 1'b0;
    if (got.kind !== want.kind) begin
      bad = 1'b1;
      show_field("kind", int'(want.kind), int'(got.kind));
    end
    if (got.event_signal !== want.event_signal) begin
      bad = 1'b1;
      show_field("event_signal", int'(want.event_signal), int'(got.event_signal));
    end
    if (got.event_release !== want.event_release) begin
      bad = 1'b1;
      show_field("event_release", int'(want.event_release), int'(got.event_release));
    end
    if (got.event_modifier !== want.event_modifier) begin
      bad = 1'b1;
      show_field("event_modifier", int'(want.event_modifier), int'(got.event_modifier));
    end
    if (got.forward_velocity !== want.forward_velocity) begin
      bad = 1'b1;
      show_field("forward_velocity", int'(want.forward_velocity),
                 int'(got.forward_velocity));
    end
    if (got.lateral_velocity !== want.lateral_velocity) begin
      bad = 1'b1;
      show_field("lateral_velocity", int'(want.lateral_velocity),
                 int'(got.lateral_velocity));
    end
    if (got.turn_rate !== want.turn_rate) begin
      bad = 1'b1;
      show_field("turn_rate", int'(want.turn_rate), int'(got.turn_rate));
    end
    if (got.last !== want.last) begin
      bad = 1'b1;
      show_field("last", int'(want.last), int'(got.last));
    end
    if (bad) errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain    = LIN_GAIN_RST;
      ang_gain    = ANG_GAIN_RST;
      deadband    = DEADBAND_RST;
      zero_band   = ZERO_BAND_RST;
      held        = '0;
      axis_lx     = '0;
      axis_ly     = '0;
      axis_rx     = '0;
      prev_level  = '0;
      fresh       = 1'b1;
      quiet_ticks = '0;
      zero_run    = ZH_W'(ZERO_HOLD_TICKS);
      owed_q.delete();
      pending     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LINEAR_GAIN:      lin_gain  = cfg_data_i;
          CFG_ANGULAR_GAIN:     ang_gain  = cfg_data_i;
          CFG_STICK_DEADBAND:   deadband  = cfg_data_i;
          CFG_OUTPUT_ZERO_BAND: zero_band = cfg_data_i;
          default: ;
        endcase
      end
      // Predict first so that a result can never overtake its own item.
      if (item_valid_i && item_ready_i) begin
        if (item_data_i.op == OP_SNAPSHOT) absorb_snapshot(item_data_i);
        else run_tick();
      end
      if (result_valid_i && result_ready_i) check_result(result_data_i);
      pending = owed_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// Test top: drives snapshots and ticks into the conditioner, writes its registers and reports.
`timescale 1ns / 100ps
module tb;
  import gvc_pkg::*;

  localparam int          HALF_ONE        = 1 << (AXIS_FRAC_BITS - 1);
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned TAIL_CYCLES     = 20;
  localparam longint      RUN_LIMIT_NS    = 64'd20_000_000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_reg_e         cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  int unsigned      error_count;
  int unsigned      pending;

  bit               tx_idle_on;
  bit               rx_idle_on;
  bit               hold_off_req;
  logic [10:0]      buttons;
  logic [CFG_W-1:0] cur_deadband;
  int unsigned      sent;

  gvc_stream_if #(.payload_t(gvc_in_t))  item_if ();
  gvc_stream_if #(.payload_t(gvc_out_t)) result_if ();

  gamepad_event_and_velocity_conditioner dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  gvc_result_checker u_result_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .item_valid_i   (item_if.valid),
    .item_ready_i   (item_if.ready),
    .item_data_i    (item_if.data),
    .result_valid_i (result_if.valid),
    .result_ready_i (result_if.ready),
    .result_data_i  (result_if.data),
    .error_count_o  (error_count),
    .pending_o      (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left      = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES - 1;
        result_if.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic signed [AXIS_W-1:0] pick_axis(input logic [CFG_W-1:0] db);
    int m;
    case ($urandom_range(0, 9))
      0: pick_axis = AXIS_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       pick_axis = 16'sh8000;
          1:       pick_axis = 16'sd32767;
          2:       pick_axis = 16'sd16384;
          default: pick_axis = -16'sd16384;
        endcase
      end
      2: begin
        // straddle the deadband edge
        m = int'(db) + int'($urandom_range(0, 4)) - 2;
        pick_axis = $urandom_range(0, 1) ? AXIS_W'(m) : AXIS_W'(-m);
      end
      3:       pick_axis = AXIS_W'(int'($urandom_range(0, 800)) - 400);
      default: pick_axis = AXIS_W'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [AXIS_W-1:0] pick_dpad();
    case ($urandom_range(0, 5))
      0:       pick_dpad = AXIS_W'(HALF_ONE + int'($urandom_range(0, 1)));
      1:       pick_dpad = AXIS_W'(-HALF_ONE - int'($urandom_range(0, 1)));
      2:       pick_dpad = AXIS_W'($urandom);
      3:       pick_dpad = '0;
      default: pick_dpad = AXIS_W'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [AXIS_W-1:0] pick_trigger();
    case ($urandom_range(0, 3))
      0:       pick_trigger = AXIS_W'($urandom);
      1:       pick_trigger = '0;
      default: pick_trigger = AXIS_W'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [AXIS_W-1:0] near_zero();
    near_zero = AXIS_W'(int'($urandom_range(0, 600)) - 300);
  endfunction

  function automatic gvc_in_t build_snapshot(
      input logic [10:0] btn,
      input logic signed [AXIS_W-1:0] lx, input logic signed [AXIS_W-1:0] ly,
      input logic signed [AXIS_W-1:0] rx, input logic signed [AXIS_W-1:0] lt,
      input logic signed [AXIS_W-1:0] rt, input logic signed [AXIS_W-1:0] dh,
      input logic signed [AXIS_W-1:0] dv);
    gvc_in_t it;
    it.op                 = OP_SNAPSHOT;
    it.button_bits        = btn;
    it.left_stick_x       = lx;
    it.left_stick_y       = ly;
    it.right_stick_x      = rx;
    it.left_trigger_axis  = lt;
    it.right_trigger_axis = rt;
    it.dpad_horizontal    = dh;
    it.dpad_vertical      = dv;
    return it;
  endfunction

  // Fully random item; ticks reuse it so that their unused fields carry noise.
  function automatic gvc_in_t noise_item();
    return build_snapshot(11'($urandom), AXIS_W'($urandom), AXIS_W'($urandom),
                          AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom),
                          AXIS_W'($urandom), AXIS_W'($urandom)) |
           {op_e'($urandom_range(0, 1)), 123'd0};
  endfunction

  function automatic gvc_in_t tick_item();
    gvc_in_t it;
    it    = noise_item();
    it.op = OP_TICK;
    return it;
  endfunction

  function automatic logic [10:0] nudge(input logic [10:0] b);
    logic [10:0] r;
    r = b;
    if ($urandom_range(0, 7) == 0) return 11'($urandom);
    repeat ($urandom_range(0, 3)) r ^= 11'(1) << $urandom_range(0, 10);
    return r;
  endfunction

  task automatic gap(input int unsigned n);
    item_if.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Offer one item and hold it until taken; returns at the next falling edge.
  task automatic offer(input gvc_in_t it);
    if (tx_idle_on && $urandom_range(0, 5) == 0) gap($urandom_range(1, 16));
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Hold the sender until every owed result is out and the pipeline has settled.
  task automatic drain();
    item_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] lin, input logic [CFG_W-1:0] ang,
                              input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] zb);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_LINEAR_GAIN;
    cfg_data <= lin;
    @(negedge clk);
    cfg_idx  <= CFG_ANGULAR_GAIN;
    cfg_data <= ang;
    @(negedge clk);
    cfg_idx  <= CFG_STICK_DEADBAND;
    cfg_data <= db;
    @(negedge clk);
    cfg_idx  <= CFG_OUTPUT_ZERO_BAND;
    cfg_data <= zb;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_deadband = db;
  endtask

  task automatic snapshot_then_ticks(input int unsigned n, input bit quiet);
    buttons = nudge(buttons);
    offer(build_snapshot(buttons,
                         quiet ? near_zero() : pick_axis(cur_deadband),
                         quiet ? near_zero() : pick_axis(cur_deadband),
                         quiet ? near_zero() : pick_axis(cur_deadband),
                         pick_trigger(), pick_trigger(), pick_dpad(), pick_dpad()));
    repeat (n) offer(tick_item());
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = sent + count;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) snapshot_then_ticks($urandom_range(1, 3), 1'b0);
      else if (pick < 67) repeat ($urandom_range(10, 25)) offer(tick_item());
      else if (pick < 80) snapshot_then_ticks($urandom_range(1, 12), 1'b1);
      else offer(noise_item());
    end
  endtask

  task automatic directed_items();
    // first tick after reset: no edges, zero command
    offer(tick_item());
    offer(build_snapshot(11'h7FF, 16'sd16384, -16'sd16384, 16'sd16384, -16'sd1,
                         -16'sd16384, AXIS_W'(HALF_ONE + 1), AXIS_W'(-HALF_ONE - 1)));
    offer(tick_item());
    offer(build_snapshot(11'h000, 16'sh8000, 16'sh8000, 16'sh8000, -16'sd16384, 16'sd0,
                         AXIS_W'(-HALF_ONE - 1), AXIS_W'(HALF_ONE + 1)));
    offer(tick_item());
    // d-pad exactly at half is not held; axes on either side of the deadband
    offer(build_snapshot(11'h555, 16'sd1638, 16'sd1637, -16'sd1638, 16'sd0, 16'sd0,
                         AXIS_W'(HALF_ONE), AXIS_W'(-HALF_ONE)));
    offer(tick_item());
    offer(build_snapshot(11'h2AA, 16'sd32767, -16'sd32767, 16'sd0, 16'sd16384, -16'sd1,
                         16'sd16384, -16'sd16384));
    offer(tick_item());
    // run zero ticks past the hold count and through the silence clear
    offer(build_snapshot(11'h000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    repeat (12) offer(tick_item());
    offer(build_snapshot(11'h7FF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    offer(tick_item());
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_LINEAR_GAIN;
    cfg_data      = '0;
    item_if.valid = 1'b0;
    item_if.data  = '0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    buttons       = '0;
    cur_deadband  = DEADBAND_RST;
    sent          = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_items();
    drain();

    // long receiver hold-off while the sender keeps pushing back to back
    tx_idle_on   = 1'b0;
    hold_off_req = 1'b1;
    repeat (15) begin
      buttons = 11'($urandom);
      snapshot_then_ticks(1, 1'b0);
    end
    drain();

    tx_idle_on = 1'b1;
    run_random(60);
    drain();

    rx_idle_on = 1'b0;
    program_regs(15'd32767, 15'd32767, 15'd0, 15'd0);
    run_random(70);
    drain();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    program_regs(15'd0, 15'd0, 15'd16384, 15'd32767);
    run_random(50);
    drain();

    tx_idle_on = 1'b1;
    program_regs(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom_range(0, 2000)));
    run_random(70);
    drain();

    program_regs(15'($urandom), 15'($urandom), 15'($urandom_range(0, 400)),
                 15'($urandom_range(0, 3000)));
    run_random(70);
    drain();

    // closing stretch at full rate on both sides
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    program_regs(LIN_GAIN_RST, ANG_GAIN_RST, DEADBAND_RST, ZERO_BAND_RST);
    run_random(70);
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
